@@ hdl/baemp_pkg.sv @@
// ----------------------------------------------------------------------------
// baemp_pkg: shared definitions for the binary arithmetic encoder
// Widths, interval constants and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package baemp_pkg;

	// Interval, probability and pending counter widths.
	localparam int RANGE_BITS = 32;
	localparam int PROB_W     = 32;
	localparam int PEND_W     = 16;
	localparam int RUN_W      = 16;
	localparam int CNT_W      = $clog2(RANGE_BITS + 1);

	// Stream payload widths, padded to whole bytes.
	localparam int IN_FIELDS_W  = 2 * PROB_W + 1;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + RUN_W + PROB_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Interval landmarks.
	localparam logic [RANGE_BITS-1:0] R_MAX   = '1;
	localparam logic [RANGE_BITS-1:0] R_HALF  = {1'b1, {(RANGE_BITS - 1){1'b0}}};
	localparam logic [RANGE_BITS-1:0] R_QUAR  = {2'b01, {(RANGE_BITS - 2){1'b0}}};
	localparam logic [RANGE_BITS-1:0] R_3QUAR = {2'b11, {(RANGE_BITS - 2){1'b0}}};
	localparam logic [PEND_W-1:0]     PEND_MAX = '1;
	localparam logic [RUN_W-1:0]      RUN_MAX  = '1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // item accepted this cycle
		logic mul;      // form both products
		logic update;   // apply the split point
		logic step;     // one renormalization shift
		logic flush;    // emit the terminating bit
	} baemp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic shift;     // some renormalization case applies
		logic emit;      // that case emits a code bit
		logic out_free;  // output register can take a result this cycle
		logic chunk_end; // current item closes its chunk
	} baemp_sts_t;

	// Pending count as reported, saturated to the run length width.
	function automatic logic [RUN_W-1:0] sat_run(input logic [PEND_W-1:0] pend);
		logic [31:0] wide;
		wide = 32'(pend);
		return (wide > 32'(RUN_MAX)) ? RUN_MAX : wide[RUN_W-1:0];
	endfunction

endpackage

@@ hdl/baemp_ctrl.sv @@
// ----------------------------------------------------------------------------
// baemp_ctrl: sequencer of the binary arithmetic encoder
// Steps each item through multiply, update and renormalization, and a closing item through flush.
// ----------------------------------------------------------------------------
module baemp_ctrl import baemp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  baemp_sts_t sts,
	output logic       s_tready,
	output baemp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_RENORM,
		ST_FLUSH
	} state_t;

	state_t             state_q;
	state_t             state_nxt;
	logic               rdy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               renorm_done;
	logic               renorm_stall;

	// Renormalization ends after the shift limit or when no case applies.
	assign renorm_done  = (cnt_q == CNT_W'(RANGE_BITS)) || !sts.shift;
	assign renorm_stall = sts.emit && !sts.out_free;

	// Commands decoded from the current state and datapath status.
	always_comb begin
		cmd         = '0;
		state_nxt   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid && rdy_q;
				if (cmd.load) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_nxt  = ST_RENORM;
			end
			ST_RENORM: begin
				if (renorm_done) begin
					state_nxt = sts.chunk_end ? ST_FLUSH : ST_IDLE;
				end else if (!renorm_stall) begin
					cmd.step = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State, shift counter and registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			rdy_q   <= (state_nxt == ST_IDLE);
			if (cmd.update) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign s_tready = rdy_q;

endmodule

@@ hdl/baemp_dp.sv @@
// ----------------------------------------------------------------------------
// baemp_dp: datapath of the binary arithmetic encoder
// Interval, probability and pending registers, products and output register.
// ----------------------------------------------------------------------------
module baemp_dp import baemp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  baemp_cmd_t        cmd,
	output baemp_sts_t        sts,
	input  logic              chunk_start,
	input  logic [PROB_W-1:0] start_prob,
	input  logic              source_bit,
	input  logic [PROB_W-1:0] prob_factor,
	input  logic              chunk_end,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              code_bit,
	output logic [RUN_W-1:0]  run_length,
	output logic              end_of_chunk,
	output logic [PROB_W-1:0] final_prob
);

	logic [RANGE_BITS-1:0]        lo_q;
	logic [RANGE_BITS-1:0]        hi_q;
	logic [PROB_W-1:0]            prob_q;
	logic [PEND_W-1:0]            pend_q;
	logic                         bit_q;
	logic                         end_q;
	logic [PROB_W-1:0]            factor_q;
	logic [PROB_W+RANGE_BITS-1:0] width_prod_q;
	logic [2*PROB_W-1:0]          prob_prod_q;
	logic                         out_valid_q;
	logic                         code_q;
	logic [RUN_W-1:0]             run_q;
	logic                         last_q;
	logic [PROB_W-1:0]            fp_q;

	logic [RANGE_BITS-1:0] width;
	logic [RANGE_BITS-1:0] split_raw;
	logic [RANGE_BITS-1:0] split_min;
	logic [RANGE_BITS:0]   split_sum;
	logic [RANGE_BITS-1:0] split;
	logic                  e1;
	logic                  e2;
	logic                  e3;
	logic [RANGE_BITS-1:0] lo_sel;
	logic [RANGE_BITS-1:0] hi_sel;
	logic [PEND_W-1:0]     pend_inc;

	// Split point, renormalization cases and saturating pending increment.
	always_comb begin
		width     = hi_q - lo_q;
		split_raw = width_prod_q[PROB_W+RANGE_BITS-1:PROB_W];
		split_min = (split_raw == '0) ? RANGE_BITS'(1) : split_raw;
		split_sum = {1'b0, lo_q} + {1'b0, split_min};
		split     = split_sum[RANGE_BITS] ? R_MAX : split_sum[RANGE_BITS-1:0];
		e1        = hi_q < R_HALF;
		e2        = lo_q >= R_HALF;
		e3        = (lo_q >= R_QUAR) && (hi_q < R_3QUAR);
		lo_sel    = (e1 || e2) ? lo_q : lo_q - R_QUAR;
		hi_sel    = (e1 || e2) ? hi_q : hi_q - R_QUAR;
		pend_inc  = (pend_q == PEND_MAX) ? pend_q : pend_q + 1'b1;
	end

	assign sts.shift     = e1 || e2 || e3;
	assign sts.emit      = e1 || e2;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.chunk_end = end_q;

	// Coder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= '0;
			hi_q   <= R_MAX;
			prob_q <= '0;
			pend_q <= '0;
		end else begin
			if (cmd.load && chunk_start) begin
				lo_q   <= '0;
				hi_q   <= R_MAX;
				pend_q <= '0;
				prob_q <= start_prob;
			end
			if (cmd.update) begin
				if (bit_q) begin
					lo_q   <= split;
					prob_q <= prob_prod_q[2*PROB_W-1:PROB_W];
				end else begin
					hi_q <= split - 1'b1;
				end
			end
			if (cmd.step) begin
				lo_q   <= {lo_sel[RANGE_BITS-2:0], 1'b0};
				hi_q   <= {hi_sel[RANGE_BITS-2:0], 1'b1};
				pend_q <= (e1 || e2) ? '0 : pend_inc;
			end
			if (cmd.flush) begin
				lo_q   <= '0;
				hi_q   <= R_MAX;
				pend_q <= '0;
			end
		end
	end

	// Item fields and the two products, both taken from the old probability.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bit_q    <= source_bit;
			end_q    <= chunk_end;
			factor_q <= prob_factor;
		end
		if (cmd.mul) begin
			width_prod_q <= (PROB_W + RANGE_BITS)'(prob_q) * (PROB_W + RANGE_BITS)'(width);
			prob_prod_q  <= (2 * PROB_W)'(prob_q) * (2 * PROB_W)'(factor_q);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.step && sts.emit) || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			code_q <= !(lo_q < R_QUAR);
			run_q  <= sat_run(pend_inc);
			last_q <= 1'b1;
			fp_q   <= prob_q;
		end else if (cmd.step && sts.emit) begin
			code_q <= !e1;
			run_q  <= sat_run(pend_q);
			last_q <= 1'b0;
			fp_q   <= '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign code_bit     = code_q;
	assign run_length   = run_q;
	assign end_of_chunk = last_q;
	assign final_prob   = fp_q;

	// A result is only written when the output register can take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.step && sts.emit) || cmd.flush) |-> sts.out_free)
		else $error("result written while output register is occupied");

	// A flush leaves the interval at its reset value with nothing pending.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (lo_q == '0) && (hi_q == R_MAX) && (pend_q == '0))
		else $error("interval not restored after flush");

	// A flush presents the chunk's last result in the next cycle.
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> out_valid_q && last_q)
		else $error("flush result missing on output");

endmodule

@@ hdl/binary_arith_encoder_mult_prob_unit.sv @@
// ----------------------------------------------------------------------------
// binary_arith_encoder_mult_prob_unit: binary arithmetic encoder, top level
// Codes one source bit per item against a 32-bit interval with a
// multiplicatively adapted probability and reports emitted code bits.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel; each result item on the m_ channel
// carries one code bit and the run of complementary bits that follow it.
// An item with tuser set starts a chunk (loads start_prob, resets the
// interval); an item with tlast set closes it, and its last result has tlast
// set and carries the final probability.
// One item is coded at a time. After acceptance it passes the multiply,
// update and renormalization states, and a closing item the flush state,
// before the next item is accepted. Renormalization makes k (0 to 32)
// shifts, one per cycle unless a code bit waits on a full output register.
// Both multiplies (split point, probability) share a registered cycle.
// Results wait in a single output register; while it is full and the
// receiver stalls, renormalization pauses at the next code bit. The next
// item is accepted while the last result still waits.
// Reset puts the interval at [0, all ones], the probability and pending
// count at zero, and empties the output register.
// ----------------------------------------------------------------------------
module binary_arith_encoder_mult_prob_unit import baemp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// start_prob [31:0], source_bit [32], prob_factor [64:33], zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// chunk_start
	input  logic                  s_tuser,
	// chunk_end
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// code_bit [0], run_length [16:1], final_prob [48:17], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// end_of_chunk
	output logic                  m_tlast
);

	baemp_cmd_t        cmd;
	baemp_sts_t        sts;
	logic              code_bit;
	logic [RUN_W-1:0]  run_length;
	logic [PROB_W-1:0] final_prob;

	baemp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	baemp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.chunk_start  (s_tuser),
		.start_prob   (s_tdata[PROB_W-1:0]),
		.source_bit   (s_tdata[PROB_W]),
		.prob_factor  (s_tdata[2*PROB_W:PROB_W+1]),
		.chunk_end    (s_tlast),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.code_bit     (code_bit),
		.run_length   (run_length),
		.end_of_chunk (m_tlast),
		.final_prob   (final_prob)
	);

	// Result fields packed from the lowest bit up.
	assign m_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, final_prob, run_length, code_bit};

endmodule
